// ===== hw/rtl/srdfd_pkg.sv =====
// ----------------------------------------------------------------------------
// srdfd_pkg: shared types and constants
// Parse phases, register map and the result record of the delta-frame decoder.
// ----------------------------------------------------------------------------
package srdfd_pkg;

  localparam int unsigned FRAME_W   = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 2;

  localparam logic [FRAME_W-1:0] FRAME_SIZE_RST = FRAME_W'(320 * 200);

  // Register byte addresses
  localparam logic [APB_AW-1:0] REG_FRAME_SIZE = APB_AW'(0);

  typedef enum logic [2:0] {
    PH_HDR0   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_SMARK  = 3'd2,
    PH_LMARK  = 3'd3,
    PH_DATA   = 3'd4,
    PH_SCOUNT = 3'd5,
    PH_WLOW   = 3'd6,
    PH_WHIGH  = 3'd7
  } phase_t;

  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] addr;
    logic [BYTE_W-1:0]  value;
    logic               wr;
    logic               done;
    logic               ovr;
  } result_t;

endpackage

// ===== hw/rtl/srdfd_cfg.sv =====
// ----------------------------------------------------------------------------
// srdfd_cfg: configuration register file
// APB-style slave holding the frame size register.
// ----------------------------------------------------------------------------
module srdfd_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [srdfd_pkg::APB_AW-1:0]      paddr,
  input  logic [srdfd_pkg::APB_DW-1:0]      pwdata,
  output logic [srdfd_pkg::APB_DW-1:0]      prdata,
  output logic                              pready,
  output logic [srdfd_pkg::FRAME_W-1:0]     frame_size
);

  logic [srdfd_pkg::FRAME_W-1:0] frame_size_r;
  logic [srdfd_pkg::FRAME_W-1:0] frame_size_nxt;
  logic                          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == srdfd_pkg::REG_FRAME_SIZE);

  always_comb begin
    frame_size_nxt = frame_size_r;
    if (wr_en) begin
      frame_size_nxt = pwdata[srdfd_pkg::FRAME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_size_r <= srdfd_pkg::FRAME_SIZE_RST;
    end else begin
      frame_size_r <= frame_size_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == srdfd_pkg::REG_FRAME_SIZE) begin
      prdata = {{(srdfd_pkg::APB_DW-srdfd_pkg::FRAME_W){1'b0}}, frame_size_r};
    end
  end

  assign frame_size = frame_size_r;

endmodule

// ===== hw/rtl/srdfd_parser.sv =====
// ----------------------------------------------------------------------------
// srdfd_parser: stream parser
// Holds the parse state and decodes one byte per step into an optional result.
// ----------------------------------------------------------------------------
module srdfd_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  logic [srdfd_pkg::BYTE_W-1:0]    data_byte,
  input  logic [srdfd_pkg::FRAME_W-1:0]   frame_size,
  output srdfd_pkg::result_t              res
);

  srdfd_pkg::phase_t             phase_r,   phase_nxt;
  logic [srdfd_pkg::FRAME_W-1:0] pos_r,     pos_nxt;
  logic [srdfd_pkg::BYTE_W-1:0]  smark_r,   smark_nxt;
  logic [srdfd_pkg::BYTE_W-1:0]  lmark_r,   lmark_nxt;
  logic [srdfd_pkg::BYTE_W-1:0]  pend_r,    pend_nxt;
  logic [srdfd_pkg::BYTE_W-1:0]  cnt_lo_r,  cnt_lo_nxt;

  logic [srdfd_pkg::FRAME_W-1:0] eff_size;
  logic [srdfd_pkg::FRAME_W:0]   lit_next;
  logic                          lit_done;
  logic [srdfd_pkg::FRAME_W-1:0] rem;
  logic [srdfd_pkg::FRAME_W-1:0] skip_len;
  logic [srdfd_pkg::FRAME_W-1:0] skip_pos;
  logic                          skip_end;
  logic                          skip_ovr;
  logic                          do_lit;
  logic                          do_skip;
  logic [srdfd_pkg::BYTE_W-1:0]  lit_val;

  assign eff_size = (frame_size == '0) ? srdfd_pkg::FRAME_W'(1) : frame_size;
  assign lit_next = {1'b0, pos_r} + (srdfd_pkg::FRAME_W+1)'(1);
  assign lit_done = lit_next >= {1'b0, eff_size};
  assign rem      = (eff_size > pos_r) ? (eff_size - pos_r) : '0;
  // word count in the high-byte phase, else the byte count
  assign skip_len = (phase_r == srdfd_pkg::PH_WHIGH) ? {data_byte, cnt_lo_r}
                  : {{(srdfd_pkg::FRAME_W-srdfd_pkg::BYTE_W){1'b0}}, data_byte};
  assign skip_end = skip_len >= rem;
  assign skip_ovr = skip_len > rem;
  assign skip_pos = pos_r + skip_len;

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    smark_nxt  = smark_r;
    lmark_nxt  = lmark_r;
    pend_nxt   = pend_r;
    cnt_lo_nxt = cnt_lo_r;
    do_lit     = 1'b0;
    do_skip    = 1'b0;
    lit_val    = data_byte;
    res        = '0;

    case (phase_r)
      srdfd_pkg::PH_HDR0:  phase_nxt = srdfd_pkg::PH_HDR1;
      srdfd_pkg::PH_HDR1:  phase_nxt = srdfd_pkg::PH_SMARK;
      srdfd_pkg::PH_SMARK: begin
        smark_nxt = data_byte;
        phase_nxt = srdfd_pkg::PH_LMARK;
      end
      srdfd_pkg::PH_LMARK: begin
        lmark_nxt = data_byte;
        phase_nxt = srdfd_pkg::PH_DATA;
      end
      srdfd_pkg::PH_DATA: begin
        if (data_byte == smark_r) begin
          pend_nxt  = data_byte;
          phase_nxt = srdfd_pkg::PH_SCOUNT;
        end else if (data_byte == lmark_r) begin
          pend_nxt  = data_byte;
          phase_nxt = srdfd_pkg::PH_WLOW;
        end else begin
          do_lit = 1'b1;
        end
      end
      srdfd_pkg::PH_SCOUNT: begin
        if (data_byte != '0) begin
          do_skip = 1'b1;
        end else if (pend_r == lmark_r) begin
          // equal markers: zero byte count falls through to a word count
          phase_nxt = srdfd_pkg::PH_WLOW;
        end else begin
          do_lit  = 1'b1;
          lit_val = pend_r;
        end
      end
      srdfd_pkg::PH_WLOW: begin
        cnt_lo_nxt = data_byte;
        phase_nxt  = srdfd_pkg::PH_WHIGH;
      end
      srdfd_pkg::PH_WHIGH: begin
        if ({data_byte, cnt_lo_r} != '0) begin
          do_skip = 1'b1;
        end else begin
          do_lit  = 1'b1;
          lit_val = pend_r;
        end
      end
      default: phase_nxt = srdfd_pkg::PH_HDR0;
    endcase

    if (do_lit) begin
      res.valid = 1'b1;
      res.addr  = pos_r;
      res.value = lit_val;
      res.wr    = 1'b1;
      res.done  = lit_done;
      if (lit_done) begin
        pos_nxt   = '0;
        phase_nxt = srdfd_pkg::PH_HDR0;
      end else begin
        pos_nxt   = lit_next[srdfd_pkg::FRAME_W-1:0];
        phase_nxt = srdfd_pkg::PH_DATA;
      end
    end

    if (do_skip) begin
      if (skip_end) begin
        res.valid = 1'b1;
        res.done  = 1'b1;
        res.ovr   = skip_ovr;
        pos_nxt   = '0;
        phase_nxt = srdfd_pkg::PH_HDR0;
      end else begin
        pos_nxt   = skip_pos;
        phase_nxt = srdfd_pkg::PH_DATA;
      end
    end

    if (!step) begin
      phase_nxt  = phase_r;
      pos_nxt    = pos_r;
      smark_nxt  = smark_r;
      lmark_nxt  = lmark_r;
      pend_nxt   = pend_r;
      cnt_lo_nxt = cnt_lo_r;
      res.valid  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= srdfd_pkg::PH_HDR0;
      pos_r    <= '0;
      smark_r  <= '0;
      lmark_r  <= '0;
      pend_r   <= '0;
      cnt_lo_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      smark_r  <= smark_nxt;
      lmark_r  <= lmark_nxt;
      pend_r   <= pend_nxt;
      cnt_lo_r <= cnt_lo_nxt;
    end
  end

endmodule

// ===== hw/rtl/skip_run_delta_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// skip_run_delta_frame_decoder_core: delta-frame byte stream decoder
// Input byte register, parser and result register with valid/stall channels.
// ----------------------------------------------------------------------------
// Takes one stream byte per beat and gives at most one result per byte: a
// literal pixel write, or a frame-end beat after a skip that reaches the
// frame end. Throughput is one byte per clock while out_stall is low; a
// byte passes through the input register, then the parser into the result
// register. The input register keeps taking bytes while a result waits to
// be taken, until both registers are full. Write frame_size (offset 0) only
// while the stream is idle.
module skip_run_delta_frame_decoder_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [srdfd_pkg::BYTE_W-1:0]    in_data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [srdfd_pkg::FRAME_W-1:0]   out_pixel_address,
  output logic [srdfd_pkg::BYTE_W-1:0]    out_pixel_value,
  output logic                            out_pixel_write,
  output logic                            out_frame_done,
  output logic                            out_overrun,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [srdfd_pkg::APB_AW-1:0]    paddr,
  input  logic [srdfd_pkg::APB_DW-1:0]    pwdata,
  output logic [srdfd_pkg::APB_DW-1:0]    prdata,
  output logic                            pready
);

  logic [srdfd_pkg::FRAME_W-1:0] frame_size;
  logic                          in_vld_r, in_vld_nxt;
  logic [srdfd_pkg::BYTE_W-1:0]  in_byte_r, in_byte_nxt;
  logic                          out_vld_r, out_vld_nxt;
  srdfd_pkg::result_t            out_res_r, out_res_nxt;
  srdfd_pkg::result_t            res;
  logic                          in_take;
  logic                          step;

  srdfd_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .frame_size (frame_size)
  );

  srdfd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .data_byte  (in_byte_r),
    .frame_size (frame_size),
    .res        (res)
  );

  // parse a held byte whenever the result slot is free or draining
  assign step     = in_vld_r && !(out_vld_r && out_stall);
  assign in_stall = in_vld_r && !step;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt  = in_vld_r;
    in_byte_nxt = in_byte_r;
    if (in_take) begin
      in_vld_nxt  = 1'b1;
      in_byte_nxt = in_data_byte;
    end else if (step) begin
      in_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
    if (res.valid) begin
      out_vld_nxt = 1'b1;
      out_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_byte_r <= in_byte_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid         = out_vld_r;
  assign out_pixel_address = out_res_r.addr;
  assign out_pixel_value   = out_res_r.value;
  assign out_pixel_write   = out_res_r.wr;
  assign out_frame_done    = out_res_r.done;
  assign out_overrun       = out_res_r.ovr;

endmodule
